// ===== hw/rtl/apq_pkg.sv =====
// Shared types, codes and defaults for the array min priority queue.
package apq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned OCC_W        = 5;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
  } slot_t;

endpackage

// ===== hw/rtl/array_min_priority_queue.sv =====
// A full or empty answer goes straight from idle to the finish state; other words scan first.
// One word at a time: a new word is taken only once the last answer is in the output register;
// a scan uses the single slot memory read port and one shared comparator, one slot per cycle.
// An insert stops at the first free slot; a remove always reads all CAPACITY slots.
// Reset: asynchronous, active low; afterwards a clearing pass writes every slot free
// before the first word is accepted.
module array_min_priority_queue #(
  parameter int unsigned CAPACITY = apq_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              req_type_i,
  input  logic signed [apq_pkg::VAL_W-1:0]  item_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [apq_pkg::STATUS_W-1:0]      status_o,
  output logic signed [apq_pkg::VAL_W-1:0]  removed_value_o,
  output logic [apq_pkg::OCC_W-1:0]         occupancy_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  apq_pkg::state_e  state_q, state_d;
  logic [IDX_W-1:0] rd_addr_q, rd_addr_d;
  logic [CNT_W-1:0] iss_cnt_q, iss_cnt_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_addr_q;
  logic             out_valid_q, out_valid_d;

  logic                             req_q, req_d;
  logic signed [apq_pkg::VAL_W-1:0] item_q, item_d;
  apq_pkg::status_e                 res_status_q, res_status_d;
  logic signed [apq_pkg::VAL_W-1:0] res_value_q, res_value_d;
  apq_pkg::status_e                 out_status_q;
  logic signed [apq_pkg::VAL_W-1:0] out_value_q;
  logic [apq_pkg::OCC_W-1:0]        out_occ_q;

  logic             in_acc;
  logic             load_out;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr;
  apq_pkg::slot_t   mem_wdata, mem_rdata;
  logic             scan_found;
  logic [IDX_W-1:0] scan_idx;
  logic signed [apq_pkg::VAL_W-1:0] scan_value;
  logic             scan_done;

  apq_mem #(
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_addr_q),
    .rdata_o (mem_rdata)
  );

  apq_scan #(
    .AW (IDX_W)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc),
    .remove_i (req_q),
    .hit_i    (cmp_vld_q),
    .addr_i   (cmp_addr_q),
    .slot_i   (mem_rdata),
    .found_o  (scan_found),
    .idx_o    (scan_idx),
    .value_o  (scan_value)
  );

  assign in_ready_o = (state_q == apq_pkg::S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_out   = (state_q == apq_pkg::S_FINISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    if (req_q == apq_pkg::REQ_REMOVE) begin
      scan_done = cmp_vld_q && (cmp_addr_q == IDX_W'(CAPACITY - 1));
    end else begin
      scan_done = scan_found;
    end
  end

  always_comb begin
    state_d      = state_q;
    rd_addr_d    = rd_addr_q;
    iss_cnt_d    = iss_cnt_q;
    count_d      = count_q;
    req_d        = req_q;
    item_d       = item_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = rd_addr_q;
    mem_wdata    = '0;
    out_valid_d  = out_valid_q && !out_ready_i;

    unique case (state_q)
      apq_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        rd_addr_d = rd_addr_q + 1'b1;
        if (rd_addr_q == IDX_W'(CAPACITY - 1)) begin
          state_d = apq_pkg::S_IDLE;
        end
      end
      apq_pkg::S_IDLE: begin
        if (in_acc) begin
          req_d       = req_type_i;
          item_d      = item_value_i;
          rd_addr_d   = '0;
          iss_cnt_d   = '0;
          res_value_d = '0;
          if (req_type_i == apq_pkg::REQ_INSERT && count_q == CNT_W'(CAPACITY)) begin
            res_status_d = apq_pkg::ST_FULL;
            state_d      = apq_pkg::S_FINISH;
          end else if (req_type_i == apq_pkg::REQ_REMOVE && count_q == '0) begin
            res_status_d = apq_pkg::ST_EMPTY;
            state_d      = apq_pkg::S_FINISH;
          end else begin
            res_status_d = apq_pkg::ST_DONE;
            state_d      = apq_pkg::S_SCAN;
          end
        end
      end
      apq_pkg::S_SCAN: begin
        // issue one slot read per cycle until all are out or the scan ends
        mem_re = (iss_cnt_q < CNT_W'(CAPACITY)) && !scan_done;
        if (mem_re) begin
          rd_addr_d = rd_addr_q + 1'b1;
          iss_cnt_d = iss_cnt_q + 1'b1;
        end
        if (scan_done) begin
          mem_we    = 1'b1;
          mem_waddr = scan_idx;
          state_d   = apq_pkg::S_FINISH;
          if (req_q == apq_pkg::REQ_REMOVE) begin
            mem_wdata.valid = 1'b0;
            mem_wdata.value = scan_value;
            res_value_d     = scan_value;
            count_d         = count_q - 1'b1;
          end else begin
            mem_wdata.valid = 1'b1;
            mem_wdata.value = item_q;
            count_d         = count_q + 1'b1;
          end
        end
      end
      apq_pkg::S_FINISH: begin
        // hold the result until the output register frees up
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = apq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = apq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= apq_pkg::S_CLEAR;
      rd_addr_q   <= '0;
      iss_cnt_q   <= '0;
      count_q     <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_addr_q   <= rd_addr_d;
      iss_cnt_q   <= iss_cnt_d;
      count_q     <= count_d;
      cmp_vld_q   <= mem_re;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_addr_q   <= rd_addr_q;
    req_q        <= req_d;
    item_q       <= item_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_occ_q    <= apq_pkg::OCC_W'(count_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign removed_value_o = out_value_q;
  assign occupancy_o     = out_occ_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == apq_pkg::S_CLEAR || state_q == apq_pkg::S_SCAN))
    else $error("slot write outside clear or scan");

  a_write_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == apq_pkg::S_SCAN) |-> (mem_wdata.valid == (req_q == apq_pkg::REQ_INSERT)))
    else $error("scan write sets wrong valid bit");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == apq_pkg::S_SCAN && scan_done) |=> (count_q != $past(count_q)))
    else $error("finished scan left entry count unchanged");
`endif

endmodule

// ===== hw/rtl/apq_mem.sv =====
// Slot memory: one write port, one read port, registered read data.
module apq_mem #(
  parameter int unsigned DEPTH = apq_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  apq_pkg::slot_t  wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output apq_pkg::slot_t  rdata_o
);

  apq_pkg::slot_t mem_q [DEPTH];
  apq_pkg::slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/apq_scan.sv =====
// Scan comparator: tracks the smallest occupied slot or the first free slot.
module apq_scan #(
  parameter int unsigned AW = $clog2(apq_pkg::CAPACITY_DEF)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              remove_i,
  input  logic                              hit_i,
  input  logic [AW-1:0]                     addr_i,
  input  apq_pkg::slot_t                    slot_i,
  output logic                              found_o,
  output logic [AW-1:0]                     idx_o,
  output logic signed [apq_pkg::VAL_W-1:0]  value_o
);

  logic                             found_q, found_d;
  logic [AW-1:0]                    idx_q, idx_d;
  logic signed [apq_pkg::VAL_W-1:0] val_q, val_d;
  logic                             take;

  always_comb begin
    if (remove_i) begin
      // strict less-than keeps the lowest slot on a tie
      take = hit_i && slot_i.valid && (!found_q || (slot_i.value < val_q));
    end else begin
      take = hit_i && !slot_i.valid && !found_q;
    end
    found_d = found_q | take;
    idx_d   = take ? addr_i : idx_q;
    val_d   = take ? slot_i.value : val_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (start_i) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    val_q <= val_d;
  end

  assign found_o = found_d;
  assign idx_o   = idx_d;
  assign value_o = val_d;

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the array min priority queue: directed table, then random words.
module tb;

  localparam int unsigned CAPACITY       = apq_pkg::CAPACITY_DEF;
  localparam int          N_DIR          = 26;
  localparam int          N_RAND         = 880;
  localparam int          WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    apq_pkg::status_e                 st;
    logic signed [apq_pkg::VAL_W-1:0] removed;
    logic [apq_pkg::OCC_W-1:0]        occ;
  } answer_t;

  typedef struct packed {
    logic                             req;
    logic signed [apq_pkg::VAL_W-1:0] val;
    logic                             typed;
    answer_t                          ans;
  } dir_row_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic                             req_type_i;
  logic signed [apq_pkg::VAL_W-1:0] item_value_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic [apq_pkg::STATUS_W-1:0]     status_o;
  logic signed [apq_pkg::VAL_W-1:0] removed_value_o;
  logic [apq_pkg::OCC_W-1:0]        occupancy_o;

  // shadow copy of the queue contents
  logic signed [apq_pkg::VAL_W-1:0] slot_val [CAPACITY];
  logic                             slot_used [CAPACITY];
  int                               held_count;

  answer_t answer_q [$];
  int      err_cnt;
  int      words_in;
  int      quiet_cycles;

  // Rows flagged typed carry a hand-written answer; the rest use the shadow queue.
  dir_row_t dir_tbl [0:N_DIR-1] = '{
    '{apq_pkg::REQ_REMOVE, 32'h5A5A5A5A, 1'b1, '{apq_pkg::ST_EMPTY, 32'h00000000, 5'd0}},
    '{apq_pkg::REQ_INSERT, 32'h7FFFFFFF, 1'b1, '{apq_pkg::ST_DONE,  32'h00000000, 5'd1}},
    '{apq_pkg::REQ_INSERT, 32'h80000000, 1'b1, '{apq_pkg::ST_DONE,  32'h00000000, 5'd2}},
    '{apq_pkg::REQ_REMOVE, 32'hFFFFFFFF, 1'b1, '{apq_pkg::ST_DONE,  32'h80000000, 5'd1}},
    '{apq_pkg::REQ_REMOVE, 32'h00000000, 1'b1, '{apq_pkg::ST_DONE,  32'h7FFFFFFF, 5'd0}},
    '{apq_pkg::REQ_REMOVE, 32'hA5A5A5A5, 1'b1, '{apq_pkg::ST_EMPTY, 32'h00000000, 5'd0}},
    '{apq_pkg::REQ_INSERT, 32'h00000005, 1'b0, '{apq_pkg::ST_DONE,  32'h00000000, 5'd0}},
    '{apq_pkg::REQ_INSERT, 32'hFFFFFFFD, 1'b0, '{apq_pkg::ST_DONE,  32'h00000000, 5'd0}},
    '{apq_pkg::REQ_INSERT, 32'h00000000, 1'b0, '{apq_pkg::ST_DONE,  32'h00000000, 5'd0}},
    '{apq_pkg::REQ_INSERT, 32'hFFFFFFFD, 1'b0, '{apq_pkg::ST_DONE,  32'h00000000, 5'd0}},
    '{apq_pkg::REQ_INSERT, 32'h7FFFFFFF, 1'b0, '{apq_pkg::ST_DONE,  32'h00000000, 5'd0}},
    '{apq_pkg::REQ_INSERT, 32'h80000000, 1'b0, '{apq_pkg::ST_DONE,  32'h00000000, 5'd0}},
    '{apq_pkg::REQ_INSERT, 32'hFFFFFFFF, 1'b0, '{apq_pkg::ST_DONE,  32'h00000000, 5'd0}},
    '{apq_pkg::REQ_INSERT, 32'h00000001, 1'b0, '{apq_pkg::ST_DONE,  32'h00000000, 5'd0}},
    '{apq_pkg::REQ_INSERT, 32'h80000000, 1'b0, '{apq_pkg::ST_DONE,  32'h00000000, 5'd0}},
    '{apq_pkg::REQ_INSERT, 32'h0000000C, 1'b0, '{apq_pkg::ST_DONE,  32'h00000000, 5'd0}},
    '{apq_pkg::REQ_INSERT, 32'hFFFFFF9C, 1'b0, '{apq_pkg::ST_DONE,  32'h00000000, 5'd0}},
    '{apq_pkg::REQ_INSERT, 32'h00000000, 1'b0, '{apq_pkg::ST_DONE,  32'h00000000, 5'd0}},
    '{apq_pkg::REQ_INSERT, 32'h00000005, 1'b0, '{apq_pkg::ST_DONE,  32'h00000000, 5'd0}},
    '{apq_pkg::REQ_INSERT, 32'h7FFFFFFE, 1'b0, '{apq_pkg::ST_DONE,  32'h00000000, 5'd0}},
    '{apq_pkg::REQ_INSERT, 32'h80000001, 1'b0, '{apq_pkg::ST_DONE,  32'h00000000, 5'd0}},
    '{apq_pkg::REQ_INSERT, 32'h00000003, 1'b0, '{apq_pkg::ST_DONE,  32'h00000000, 5'd0}},
    '{apq_pkg::REQ_INSERT, 32'h0000002A, 1'b1, '{apq_pkg::ST_FULL,  32'h00000000, 5'd16}},
    '{apq_pkg::REQ_REMOVE, 32'h12345678, 1'b0, '{apq_pkg::ST_DONE,  32'h00000000, 5'd0}},
    '{apq_pkg::REQ_REMOVE, 32'h87654321, 1'b0, '{apq_pkg::ST_DONE,  32'h00000000, 5'd0}},
    '{apq_pkg::REQ_INSERT, 32'h00000009, 1'b0, '{apq_pkg::ST_DONE,  32'h00000000, 5'd0}}
  };

  array_min_priority_queue #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .item_value_i   (item_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .occupancy_o    (occupancy_o)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Apply one request to the shadow queue and return the answer it should produce.
  function automatic answer_t queue_apply_request(input logic req,
                                                  input logic signed [apq_pkg::VAL_W-1:0] val);
    answer_t ans;
    int      best;
    int      s;
    ans.st      = apq_pkg::ST_DONE;
    ans.removed = '0;
    best        = -1;
    if (req == apq_pkg::REQ_INSERT) begin
      if (held_count >= CAPACITY) begin
        ans.st = apq_pkg::ST_FULL;
      end else begin
        for (s = 0; s < CAPACITY; s++) begin
          if (!slot_used[s] && best < 0) best = s;
        end
        slot_val[best]  = val;
        slot_used[best] = 1'b1;
        held_count++;
      end
    end else begin
      // strict less-than keeps the lowest slot on a tie
      for (s = 0; s < CAPACITY; s++) begin
        if (slot_used[s] && (best < 0 || slot_val[s] < slot_val[best])) best = s;
      end
      if (best < 0) begin
        ans.st = apq_pkg::ST_EMPTY;
      end else begin
        ans.removed     = slot_val[best];
        slot_used[best] = 1'b0;
        held_count--;
      end
    end
    ans.occ = held_count[apq_pkg::OCC_W-1:0];
    return ans;
  endfunction

  // Offer one word after a random gap, hold it until accepted, then log its answer.
  task automatic send_word(input logic req, input logic signed [apq_pkg::VAL_W-1:0] val,
                           input logic typed, input answer_t typed_ans);
    answer_t ans;
    int      gap;
    int      r;
    gap = 0;
    if ((words_in / 100) % 4 != 3) begin
      r = $urandom_range(99);
      if (r >= 93) gap = $urandom_range(8, 40);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    item_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    ans = queue_apply_request(req, val);
    answer_q.push_back(typed ? typed_ans : ans);
    words_in++;
  endtask

  initial begin
    int                               i;
    int                               n;
    int                               ins_pct;
    logic                             req;
    logic signed [apq_pkg::VAL_W-1:0] val;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    req_type_i   = apq_pkg::REQ_INSERT;
    item_value_i = '0;
    err_cnt      = 0;
    words_in     = 0;
    held_count   = 0;
    ins_pct      = 50;
    for (i = 0; i < CAPACITY; i++) begin
      slot_val[i]  = '0;
      slot_used[i] = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < N_DIR; i++) begin
      send_word(dir_tbl[i].req, dir_tbl[i].val, dir_tbl[i].typed, dir_tbl[i].ans);
    end

    for (n = 0; n < N_RAND; n++) begin
      // swing between filling and draining phases so full and empty both come up
      if (n % 60 == 0) begin
        case ($urandom_range(2))
          0:       ins_pct = 20;
          1:       ins_pct = 50;
          default: ins_pct = 85;
        endcase
      end
      req = ($urandom_range(99) < ins_pct) ? apq_pkg::REQ_INSERT : apq_pkg::REQ_REMOVE;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: val = $urandom;
        5, 6, 7:       val = int'($urandom_range(8)) - 4;
        default: begin
          if ($urandom_range(1)) val = 32'h7FFFFFFF - $urandom_range(3);
          else                   val = 32'h80000000 + $urandom_range(3);
        end
      endcase
      send_word(req, val, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (CAPACITY + 8) @(posedge clk_i);
    if (err_cnt == 0 && answer_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // receiver: short stalls mostly, a few long ones, calm stretches, one long hold-off
  initial begin
    int stall;
    int r;
    bit held_off;
    stall       = 0;
    held_off    = 1'b0;
    out_ready_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held_off && words_in >= 300) begin
        // hold long enough for the block to back up into its input
        held_off = 1'b1;
        stall    = 400;
      end else if (stall == 0 && (words_in / 128) % 3 != 2) begin
        r = $urandom_range(99);
        if (r < 25) stall = $urandom_range(1, 3);
        else if (r < 28) stall = $urandom_range(10, 60);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    answer_t exp_ans;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answer_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("unexpected word: status %0d removed %0d occupancy %0d",
                   status_o, removed_value_o, occupancy_o);
        end
      end else begin
        exp_ans = answer_q.pop_front();
        if (status_o !== exp_ans.st || removed_value_o !== exp_ans.removed ||
            occupancy_o !== exp_ans.occ) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch: status %0d/%0d removed %0d/%0d occupancy %0d/%0d (exp/act)",
                     exp_ans.st, status_o, exp_ans.removed, removed_value_o,
                     exp_ans.occ, occupancy_o);
          end
        end
      end
    end
  end

  // end the run if neither side moves a word for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
